/* design/ssfs_pkg.sv */
// Shared widths, register indexes, states and word types of the sprite sheet frame sequencer.
package ssfs_pkg;

  localparam int FRAME_BITS = 16;
  localparam int DIM_BITS   = 12;
  localparam int TIME_BITS  = 32;
  localparam int TIMER_BITS = TIME_BITS + 1;
  localparam int LEFT_BITS  = 2 * DIM_BITS;
  localparam int TOP_BITS   = FRAME_BITS + DIM_BITS;
  localparam int CFG_BITS   = (TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS;
  localparam int IDX_BITS   = 3;
  localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);

  localparam logic [IDX_BITS-1:0] CFG_START_FRAME   = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_END_FRAME     = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_FRAME_DELAY   = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_LOOPED        = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_SHEET_COLUMNS = 3'd4;
  localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH   = 3'd5;
  localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT  = 3'd6;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [TIME_BITS-1:0] DELAY_RESET = TIME_BITS'(65536);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DIV_GO,
    S_DIV,
    S_MUL_LEFT,
    S_MUL_TOP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic [TIME_BITS-1:0] elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_index;
    logic [LEFT_BITS-1:0]  cell_left;
    logic [TOP_BITS-1:0]   cell_top;
    logic                  frame_advanced;
  } out_word_t;

endpackage

/* design/ssfs_div.sv */
// Restoring divider that produces one quotient bit per cycle for the sheet cell lookup.
module ssfs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssfs_pkg::FRAME_BITS-1:0] dividend,
  input  logic [ssfs_pkg::DIM_BITS-1:0]   divisor,
  output logic                          done,
  output logic [ssfs_pkg::FRAME_BITS-1:0] quotient,
  output logic [ssfs_pkg::DIM_BITS-1:0]   remainder
);
  import ssfs_pkg::*;

  logic [FRAME_BITS-1:0] quo_r, quo_nxt;
  logic [DIM_BITS-1:0]   rem_r, rem_nxt;
  logic [DIM_BITS-1:0]   dsr_r, dsr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIM_BITS:0]     shifted;
  logic [DIM_BITS:0]     diff;
  logic                  ge;

  always_comb begin
    shifted  = {rem_r, quo_r[FRAME_BITS-1]};
    diff     = shifted - {1'b0, dsr_r};
    ge       = (shifted >= {1'b0, dsr_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CNT_BITS'(FRAME_BITS);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[FRAME_BITS-2:0], ge};
      rem_nxt  = ge ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
      cnt_nxt  = cnt_r - CNT_BITS'(1);
      done_nxt = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* design/sprite_sheet_frame_sequencer_core.sv */
// Top level of the sprite sheet frame sequencer: registers, timer, frame step and cell origin.
//
// Each input word is a tick carrying elapsed 16.16 time or a restart. Every accepted
// word yields exactly one result word with the frame index, its cell origin on the
// sheet and a flag that tells whether the frame stepped.
// Configuration is a plain write port: cfg_we, cfg_index and cfg_data, taken at the
// clock edge where cfg_we is high; it must only be used while the block is idle.
// A tick runs through these steps: the timer add happens at the accepting edge, then the
// frame step, the start of the bit-serial divider that splits the frame into row and
// column, the divider itself, the shared multiplier that scales them into texels, left
// first and then top, and the load of the output register. A restart or a tick whose
// start frame is not below its end frame skips the frame step. The divider produces
// one quotient bit per cycle over the frame index width. in_stall stays high from
// acceptance until the result is loaded, so one word is in work at a time and the
// next word is accepted at the earliest after that load. A result that waits in the
// output register does not block the next word, but a finished result waits while
// out_stall is high and the register is still full.
// A synchronous reset restores the register defaults, clears frame and timer and
// empties the output register.
module sprite_sheet_frame_sequencer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ssfs_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ssfs_pkg::out_word_t          out_data,
  input  logic                         cfg_we,
  input  logic [ssfs_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [ssfs_pkg::CFG_BITS-1:0] cfg_data
);
  import ssfs_pkg::*;

  state_t                state_r, state_nxt;

  logic [FRAME_BITS-1:0] start_r, end_r;
  logic [TIME_BITS-1:0]  delay_r;
  logic                  looped_r;
  logic [DIM_BITS-1:0]   cols_r, width_r, height_r;

  logic [FRAME_BITS-1:0] cur_r, cur_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  adv_r, adv_nxt;
  logic [LEFT_BITS-1:0]  left_r, left_nxt;
  logic [TOP_BITS-1:0]   top_r, top_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic                  accept;
  logic [TIMER_BITS:0]   sum;
  logic [FRAME_BITS:0]   next_frame;
  logic [DIM_BITS-1:0]   cols_eff;
  logic                  div_start, div_done;
  logic [FRAME_BITS-1:0] div_quo;
  logic [DIM_BITS-1:0]   div_rem;
  logic [FRAME_BITS-1:0] mul_a;
  logic [DIM_BITS-1:0]   mul_b;
  logic [TOP_BITS-1:0]   product;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cols_eff = (cols_r == '0) ? DIM_BITS'(1) : cols_r;
  assign product  = TOP_BITS'(mul_a) * TOP_BITS'(mul_b);

  ssfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cur_r),
    .divisor   (cols_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    timer_nxt     = timer_r;
    adv_nxt       = adv_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    sum           = {1'b0, timer_r} + (TIMER_BITS + 1)'(in_data.elapsed_time);
    next_frame    = {1'b0, cur_r} + (FRAME_BITS + 1)'(1);
    mul_a         = FRAME_BITS'(div_rem);
    mul_b         = width_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          adv_nxt = 1'b0;
          if (in_data.cmd == CMD_RESTART) begin
            cur_nxt   = start_r;
            timer_nxt = '0;
            state_nxt = S_DIV_GO;
          end else if (start_r >= end_r) begin
            state_nxt = S_DIV_GO;
          end else begin
            timer_nxt = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (timer_r > TIMER_BITS'(delay_r)) begin
          timer_nxt = timer_r - TIMER_BITS'(delay_r);
          adv_nxt   = 1'b1;
          if (next_frame < {1'b0, start_r} || next_frame > {1'b0, end_r}) begin
            cur_nxt = looped_r ? start_r : end_r;
          end else begin
            cur_nxt = next_frame[FRAME_BITS-1:0];
          end
        end
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL_LEFT;
        end
      end
      S_MUL_LEFT: begin
        left_nxt  = product[LEFT_BITS-1:0];
        state_nxt = S_MUL_TOP;
      end
      S_MUL_TOP: begin
        mul_a     = div_quo;
        mul_b     = height_r;
        top_nxt   = product;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.frame_index    = cur_r;
          out_data_nxt.cell_left      = left_r;
          out_data_nxt.cell_top       = top_r;
          out_data_nxt.frame_advanced = adv_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      timer_r     <= '0;
      start_r     <= '0;
      end_r       <= '0;
      delay_r     <= DELAY_RESET;
      looped_r    <= 1'b0;
      cols_r      <= DIM_BITS'(1);
      width_r     <= DIM_BITS'(1);
      height_r    <= DIM_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      timer_r     <= timer_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_FRAME:   start_r  <= cfg_data[FRAME_BITS-1:0];
          CFG_END_FRAME:     end_r    <= cfg_data[FRAME_BITS-1:0];
          CFG_FRAME_DELAY:   delay_r  <= cfg_data[TIME_BITS-1:0];
          CFG_LOOPED:        looped_r <= cfg_data[0];
          CFG_SHEET_COLUMNS: cols_r   <= cfg_data[DIM_BITS-1:0];
          CFG_FRAME_WIDTH:   width_r  <= cfg_data[DIM_BITS-1:0];
          CFG_FRAME_HEIGHT:  height_r <= cfg_data[DIM_BITS-1:0];
          default: ;
        endcase
      end
    end
    adv_r      <= adv_nxt;
    left_r     <= left_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/ssfs_chk.sv */
// Port checker for the sprite sheet frame sequencer and its bind to the top level.
module ssfs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ssfs_pkg::out_word_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Block is not idle and empty after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second word was taken while the first was still in work.");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 in_stall)
    else $error("A word left the block before its result could be formed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("A stalled result word changed or was dropped.");

endmodule

bind sprite_sheet_frame_sequencer_core ssfs_chk u_ssfs_chk (.*);

/* bench/tb_sprite_sheet_frame_sequencer_core.sv */
// Testbench of the sprite sheet frame sequencer: directed and random words checked against a predictor.
module tb_sprite_sheet_frame_sequencer_core;
  import ssfs_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;
  localparam logic [TIME_BITS-1:0]  DT_MAX     = '1;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  in_word_t            in_data    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  out_word_t           out_data;
  logic                cfg_we     = 1'b0;
  logic [IDX_BITS-1:0] cfg_index  = '0;
  logic [CFG_BITS-1:0] cfg_data   = '0;

  logic [FRAME_BITS-1:0] rng_start  = '0;
  logic [FRAME_BITS-1:0] rng_end    = '0;
  logic [TIME_BITS-1:0]  step_delay = DELAY_RESET;
  logic                  wrap_on    = 1'b0;
  logic [DIM_BITS-1:0]   sheet_cols = DIM_BITS'(1);
  logic [DIM_BITS-1:0]   cell_w     = DIM_BITS'(1);
  logic [DIM_BITS-1:0]   cell_h     = DIM_BITS'(1);
  logic [FRAME_BITS-1:0] play_frame = '0;
  logic [TIMER_BITS-1:0] play_time  = '0;

  out_word_t cells_due[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 34;
  int        recv_stall_pct = 48;
  int        hold_req       = 0;
  int        hold_left      = 0;

  sprite_sheet_frame_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic out_word_t advance_animation(input in_word_t w);
    out_word_t         r;
    logic [TIMER_BITS:0] sum;
    logic [FRAME_BITS:0] next;
    longint unsigned   f;
    longint unsigned   cols;
    r.frame_advanced = 1'b0;
    if (w.cmd == CMD_RESTART) begin
      play_frame = rng_start;
      play_time  = '0;
    end else if (rng_start < rng_end) begin
      sum = {1'b0, play_time} + (TIMER_BITS + 1)'(w.elapsed_time);
      play_time = (sum > {1'b0, TIMER_FULL}) ? TIMER_FULL : sum[TIMER_BITS-1:0];
      if (play_time > TIMER_BITS'(step_delay)) begin
        play_time = play_time - TIMER_BITS'(step_delay);
        next = {1'b0, play_frame} + (FRAME_BITS + 1)'(1);
        if (next < {1'b0, rng_start} || next > {1'b0, rng_end}) begin
          next = wrap_on ? {1'b0, rng_start} : {1'b0, rng_end};
        end
        play_frame = next[FRAME_BITS-1:0];
        r.frame_advanced = 1'b1;
      end
    end
    f    = play_frame;
    cols = (sheet_cols == 0) ? 1 : sheet_cols;
    r.frame_index = play_frame;
    r.cell_left   = LEFT_BITS'((f % cols) * cell_w);
    r.cell_top    = TOP_BITS'((f / cols) * cell_h);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input logic cmd, input logic [TIME_BITS-1:0] dt);
    in_word_t w;
    w.cmd          = cmd;
    w.elapsed_time = dt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    cells_due.push_back(advance_animation(w));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_START_FRAME:   rng_start  = val[FRAME_BITS-1:0];
      CFG_END_FRAME:     rng_end    = val[FRAME_BITS-1:0];
      CFG_FRAME_DELAY:   step_delay = val[TIME_BITS-1:0];
      CFG_LOOPED:        wrap_on    = val[0];
      CFG_SHEET_COLUMNS: sheet_cols = val[DIM_BITS-1:0];
      CFG_FRAME_WIDTH:   cell_w     = val[DIM_BITS-1:0];
      CFG_FRAME_HEIGHT:  cell_h     = val[DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned lo, input int unsigned hi,
                            input logic [TIME_BITS-1:0] dly, input logic wrap,
                            input int unsigned cols, input int unsigned w,
                            input int unsigned h);
    wait_idle();
    write_reg(CFG_START_FRAME, CFG_BITS'(lo));
    write_reg(CFG_END_FRAME, CFG_BITS'(hi));
    write_reg(CFG_FRAME_DELAY, CFG_BITS'(dly));
    write_reg(CFG_LOOPED, CFG_BITS'(wrap));
    write_reg(CFG_SHEET_COLUMNS, CFG_BITS'(cols));
    write_reg(CFG_FRAME_WIDTH, CFG_BITS'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_BITS'(h));
  endtask

  // With the default range of frame zero only, ticks hold frame zero and never step.
  task automatic test_reset_defaults();
    send_word(CMD_TICK, DT_MAX);
    send_word(CMD_TICK, '0);
    send_word(CMD_RESTART, DT_MAX);
  endtask

  task automatic test_range_stepping();
    set_config(0, 3, 32'h0001_0000, 1'b1, 2, 16, 8);
    send_word(CMD_RESTART, '0);
    send_word(CMD_TICK, 32'h0001_0000);
    send_word(CMD_TICK, 32'd1);
    send_word(CMD_TICK, 32'h0000_FFFF);
    send_word(CMD_TICK, 32'h0002_0000);
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, 32'd5);
    wait_idle();
    write_reg(CFG_LOOPED, CFG_BITS'(0));
    repeat (4) send_word(CMD_TICK, DT_MAX);
  endtask

  // The top of the frame range holds at the end, and the timer saturates.
  task automatic test_top_of_range();
    set_config(16'hFFFE, 16'hFFFF, 32'd1, 1'b0, 4095, 4095, 4095);
    send_word(CMD_RESTART, DT_MAX);
    repeat (3) send_word(CMD_TICK, DT_MAX);
  endtask

  task automatic test_outside_range();
    set_config(10, 20, DT_MAX, 1'b1, 1, 4095, 4095);
    send_word(CMD_TICK, DT_MAX);
    send_word(CMD_TICK, '0);
    set_config(30, 40, 32'd1, 1'b0, 7, 3, 5);
    send_word(CMD_TICK, 32'd2);
  endtask

  // The receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    set_config(0, 7, 32'h0000_0100, 1'b1, 3, 10, 10);
    send_word(CMD_RESTART, '0);
    hold_req = 300;
    repeat (12) send_word(CMD_TICK, $urandom_range(0, 32'h0000_0300));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_words);
    int                   sent;
    int                   seg_len;
    int                   lo;
    int                   hi;
    logic [TIME_BITS-1:0] dly;
    logic [TIME_BITS-1:0] dt;
    sent = 0;
    while (sent < n_words) begin
      lo = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        0: hi = $urandom_range(0, lo);
        1: begin
          hi = 65535;
          lo = 65535 - $urandom_range(1, 8);
        end
        default: begin
          hi = lo + $urandom_range(1, 24);
          if (hi > 65535) hi = 65535;
        end
      endcase
      case ($urandom_range(0, 3))
        0: dly = $urandom_range(1, 256);
        1: dly = $urandom_range(1, 32'h0003_0000);
        2: dly = $urandom_range(1, 32'h0100_0000);
        default: begin
          dly = $urandom;
          if (dly == 0) dly = 1;
        end
      endcase
      set_config(lo, hi, dly, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? $urandom_range(1, 4095) : $urandom_range(1, 8),
                 $urandom_range(0, 1) ? $urandom_range(1, 4095) : $urandom_range(1, 8),
                 $urandom_range(0, 1) ? $urandom_range(1, 4095) : $urandom_range(1, 8));
      send_word(CMD_RESTART, $urandom);
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) begin
        case ($urandom_range(0, 5))
          0: dt = $urandom;
          1: dt = '0;
          2: dt = dly;
          3: dt = $urandom_range(0, dly);
          default: dt = dly + 1 + $urandom_range(0, 3);
        endcase
        send_word(($urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_TICK, dt);
      end
      sent += seg_len + 1;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        report_mismatch("result with nothing due, frame_index", out_data.frame_index, 0);
      end else begin
        due = cells_due.pop_front();
        if (out_data.frame_index !== due.frame_index)
          report_mismatch("frame_index", out_data.frame_index, due.frame_index);
        if (out_data.cell_left !== due.cell_left)
          report_mismatch("cell_left", out_data.cell_left, due.cell_left);
        if (out_data.cell_top !== due.cell_top)
          report_mismatch("cell_top", out_data.cell_top, due.cell_top);
        if (out_data.frame_advanced !== due.frame_advanced)
          report_mismatch("frame_advanced", out_data.frame_advanced, due.frame_advanced);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_range_stepping();
    test_top_of_range();
    test_outside_range();
    test_random_traffic(330);
    send_idle_pct  = 48;
    recv_stall_pct = 34;
    test_random_traffic(330);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random_traffic(330);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
